### rtl/bone_weight_top4_normalizer_top_macros.svh
// Assertion macros for the bone weight normalizer.
`ifndef BONE_WEIGHT_TOP4_NORMALIZER_TOP_MACROS_SVH
`define BONE_WEIGHT_TOP4_NORMALIZER_TOP_MACROS_SVH

// Plain clocked check, off while reset is asserted.
`define BWN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define BWN_ASSERT_IMP(lbl, ante, cons, msg) \
  `BWN_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

### rtl/bwn_pkg.sv
// Shared types, constants and the divide step of the bone weight normalizer.
package bwn_pkg;

  localparam int SLOTS    = 4;
  localparam int BONE_W   = 8;
  localparam int WGT_W    = 16;
  localparam int CNT_W    = 3;
  localparam int FRAC     = 15;
  localparam int SUM_W    = WGT_W + 2;
  localparam int REM_W    = SUM_W + 1;
  localparam int QUO_W    = FRAC + 1;
  localparam int DIV_CYC  = QUO_W / 2;
  localparam int STEP_W   = $clog2(DIV_CYC);
  localparam int IN_DW    = 24;
  localparam int OUT_DW   = 104;
  localparam int OUT_USED = CNT_W + SLOTS * BONE_W + SLOTS * WGT_W;

  localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(DIV_CYC - 1);
  localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(SLOTS);

  // One finished vertex handed from the front to the back.
  typedef struct packed {
    logic [CNT_W-1:0]             cnt;
    logic [SLOTS-1:0][BONE_W-1:0] bone;
    logic [SLOTS-1:0][WGT_W-1:0]  wgt;
  } vtx_t;

  // Queue status seen by the front and the checks.
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // One restoring divide step: {quotient bit, next partial remainder}.
  function automatic logic [REM_W:0] div_step(input logic [REM_W-1:0] r,
                                               input logic [SUM_W-1:0] d);
    logic [REM_W-1:0] t;
    logic             ge;
    ge = (r >= REM_W'(d));
    t  = ge ? (r - REM_W'(d)) : r;
    return {ge, t[REM_W-2:0], 1'b0};
  endfunction

endpackage

### rtl/bwn_front.sv
// Front: threshold filter and top-four sorted insertion, one pair per cycle while the queue has room.
module bwn_front import bwn_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [WGT_W-1:0]  cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [BONE_W-1:0] bone_i,
  input  logic [WGT_W-1:0]  weight_i,
  input  logic              last_i,
  input  qstat_t            q_stat_i,
  output logic              push_o,
  output vtx_t              push_data_o
);

  logic [WGT_W-1:0]             thr_q;
  logic [SLOTS-1:0][WGT_W-1:0]  slot_w_q, slot_w_d;
  logic [SLOTS-1:0][BONE_W-1:0] slot_b_q, slot_b_d;
  logic [CNT_W-1:0]             cnt_q, cnt_d;
  logic [CNT_W-1:0]             pos;
  logic                         hit, do_ins, accept;

  assign in_ready_o = !q_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept && last_i;

  // first slot holding a strictly smaller weight; ties stay behind
  always_comb begin
    pos = cnt_q;
    hit = 1'b0;
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (weight_i > slot_w_q[k]) begin
        pos = CNT_W'(k);
        hit = 1'b1;
      end
    end
    do_ins = (weight_i > thr_q) && (hit || (cnt_q < CNT_FULL));
  end

  always_comb begin
    slot_w_d = slot_w_q;
    slot_b_d = slot_b_q;
    if (do_ins) begin
      if (pos == '0) begin
        slot_w_d[0] = weight_i;
        slot_b_d[0] = bone_i;
      end
      for (int j = 1; j < SLOTS; j++) begin
        if (CNT_W'(j) == pos) begin
          slot_w_d[j] = weight_i;
          slot_b_d[j] = bone_i;
        end else if (CNT_W'(j) > pos) begin
          slot_w_d[j] = slot_w_q[j-1];
          slot_b_d[j] = slot_b_q[j-1];
        end
      end
    end
    cnt_d = (do_ins && (cnt_q < CNT_FULL)) ? cnt_q + 1'b1 : cnt_q;
  end

  assign push_data_o.cnt  = cnt_d;
  assign push_data_o.bone = slot_b_d;
  assign push_data_o.wgt  = slot_w_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= WGT_W'(32);
      slot_w_q <= '0;
      slot_b_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (accept) begin
        if (last_i) begin
          slot_w_q <= '0;
          slot_b_q <= '0;
          cnt_q    <= '0;
        end else begin
          slot_w_q <= slot_w_d;
          slot_b_q <= slot_b_d;
          cnt_q    <= cnt_d;
        end
      end
    end
  end

endmodule

### rtl/bwn_queue.sv
// Two-entry queue of finished vertices between front and back.
module bwn_queue import bwn_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  vtx_t   push_data_i,
  input  logic   pop_i,
  output vtx_t   head_o,
  output qstat_t stat_o
);

  vtx_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] fill_q;

  assign head_o       = mem_q[rd_q];
  assign stat_o.full  = (fill_q == 2'd2);
  assign stat_o.empty = (fill_q == 2'd0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      fill_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop_i) begin
        rd_q <= !rd_q;
      end
      case ({push_i, pop_i})
        2'b10:   fill_q <= fill_q + 1'b1;
        2'b01:   fill_q <= fill_q - 1'b1;
        default: fill_q <= fill_q;
      endcase
    end
  end

endmodule

### rtl/bwn_back.sv
// Back: kept sum and four lanes of restoring division, two bits per cycle.
module bwn_back import bwn_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  qstat_t            q_stat_i,
  input  vtx_t              q_head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [OUT_DW-1:0] out_data_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIN
  } state_e;

  state_e                        state_q;
  logic [STEP_W-1:0]             step_q;
  logic [CNT_W-1:0]              cnt_q;
  logic [SLOTS-1:0][BONE_W-1:0]  bone_q;
  logic [SUM_W-1:0]              sum_q;
  logic [REM_W-1:0]              rem_q [SLOTS];
  logic [QUO_W-1:0]              quo_q [SLOTS];
  logic [REM_W:0]                s1 [SLOTS];
  logic [REM_W:0]                s2 [SLOTS];
  logic [SUM_W-1:0]              head_sum;
  logic [SLOTS-1:0][WGT_W-1:0]   nw;
  logic                          load;

  assign pop_o = (state_q == ST_IDLE) && !q_stat_i.empty;
  assign load  = (state_q == ST_FIN) && (!out_valid_o || out_ready_i);

  always_comb begin
    head_sum = '0;
    for (int j = 0; j < SLOTS; j++) begin
      head_sum = head_sum + SUM_W'(q_head_i.wgt[j]);
    end
  end

  always_comb begin
    for (int j = 0; j < SLOTS; j++) begin
      s1[j] = div_step(rem_q[j], sum_q);
      s2[j] = div_step(s1[j][REM_W-1:0], sum_q);
      // empty vertex divides by zero; its fields read as zero
      nw[j] = (cnt_q == '0) ? '0 : quo_q[j];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      cnt_q       <= '0;
      bone_q      <= '0;
      sum_q       <= '0;
      out_valid_o <= 1'b0;
      out_data_o  <= '0;
      for (int j = 0; j < SLOTS; j++) begin
        rem_q[j] <= '0;
        quo_q[j] <= '0;
      end
    end else begin
      if (load) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            cnt_q  <= q_head_i.cnt;
            bone_q <= q_head_i.bone;
            sum_q  <= head_sum;
            step_q <= '0;
            for (int j = 0; j < SLOTS; j++) begin
              rem_q[j] <= REM_W'(q_head_i.wgt[j]);
              quo_q[j] <= '0;
            end
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          for (int j = 0; j < SLOTS; j++) begin
            rem_q[j] <= s2[j][REM_W-1:0];
            quo_q[j] <= {quo_q[j][QUO_W-3:0], s1[j][REM_W], s2[j][REM_W]};
          end
          step_q <= step_q + 1'b1;
          if (step_q == DIV_LAST) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (load) begin
            out_data_o  <= {(OUT_DW - OUT_USED)'(0), nw, bone_q, cnt_q};
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

### rtl/bone_weight_top4_normalizer_top.sv
// Top level of the bone weight top-four selector and normalizer.
//
//  channel   dir  handshake                     beat contents
//  s_axis    in   s_axis_tvalid/s_axis_tready   one (bone, weight) pair, tlast ends vertex
//  m_axis    out  m_axis_tvalid/m_axis_tready   one normalized vertex
//  cfg       in   cfg_we_i                      drop_threshold write
//
//  Input pairs: one per cycle while the queue has room; the front sorts each into
//  the top-four list on arrival. Per vertex the back loads and sums, runs two-bit
//  divides in four parallel lanes, then moves the result into the output register.
//  A two-entry vertex queue decouples them; the front stalls on every beat while
//  both entries are taken. The output register holds while m_axis_tready is low.
//  Reset is asynchronous, active low; threshold returns to 32, all but queue storage cleared.
`include "bone_weight_top4_normalizer_top_macros.svh"

module bone_weight_top4_normalizer_top import bwn_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [WGT_W-1:0]  cfg_wdata_i,     // drop_threshold, Q1.15
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [IN_DW-1:0]  s_axis_tdata,    // [7:0] bone_index, [23:8] weight
  input  logic              s_axis_tlast,    // last_of_vertex
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // [2:0] kept_count, [10:3] bone_0, [18:11] bone_1, [26:19] bone_2,
  // [34:27] bone_3, [50:35] norm_weight_0, [66:51] norm_weight_1,
  // [82:67] norm_weight_2, [98:83] norm_weight_3, [103:99] zero
  output logic [OUT_DW-1:0] m_axis_tdata
);

  qstat_t q_stat;
  vtx_t   q_push_data, q_head;
  logic   q_push, q_pop;

  bwn_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .bone_i      (s_axis_tdata[BONE_W-1:0]),
    .weight_i    (s_axis_tdata[BONE_W+WGT_W-1:BONE_W]),
    .last_i      (s_axis_tlast),
    .q_stat_i    (q_stat),
    .push_o      (q_push),
    .push_data_o (q_push_data)
  );

  bwn_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .pop_i       (q_pop),
    .head_o      (q_head),
    .stat_o      (q_stat)
  );

  bwn_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .q_head_i    (q_head),
    .pop_o       (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

  // total of the normalized weights; truncation loses under one LSB per slot
  logic [SUM_W-1:0] nw_sum;
  logic [CNT_W-1:0] out_cnt;
  logic             norm_ok;
  assign nw_sum = SUM_W'(m_axis_tdata[50:35]) + SUM_W'(m_axis_tdata[66:51])
                + SUM_W'(m_axis_tdata[82:67]) + SUM_W'(m_axis_tdata[98:83]);
  assign out_cnt = m_axis_tdata[CNT_W-1:0];
  assign norm_ok = (nw_sum <= 18'd32768) && (nw_sum >= 18'd32765);

  `BWN_ASSERT_IMP(a_push_room, q_push, !q_stat.full, "vertex pushed into full queue")
  `BWN_ASSERT_IMP(a_pop_data, q_pop, !q_stat.empty, "vertex popped from empty queue")
  `BWN_ASSERT_IMP(a_cnt_range, m_axis_tvalid, out_cnt <= CNT_FULL, "kept_count over four")
  `BWN_ASSERT_IMP(a_norm_sum, m_axis_tvalid && (out_cnt != '0), norm_ok, "weights not normalized")

endmodule
